// File: design/srav_pkg.sv
package srav_pkg;

   // Field and datapath widths
   localparam int ALT_W       = 24;
   localparam int DIFF_W      = ALT_W + 1;
   localparam int SPS_W       = 16;
   localparam int ALPHA_W     = 9;
   localparam int ALPHA_SHIFT = 8;
   localparam int ALPHA_ONE   = 1 << ALPHA_SHIFT;
   localparam int FRAC_W      = 7;
   localparam int RATE_W      = DIFF_W + SPS_W;
   localparam int SMOOTH_W    = 48;
   localparam int SUM_W       = 56;
   localparam int NEW_W       = RATE_W + ALPHA_W;
   localparam int OLD_W       = SMOOTH_W + ALPHA_W;
   localparam int MIX_W       = OLD_W + 1;
   localparam int MIX_HALF    = 1 << (ALPHA_SHIFT - 1);
   localparam int MUL_A_W     = SMOOTH_W;
   localparam int MUL_B_W     = SPS_W + 1;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int OUT_W       = 32;

   // Window and mean divider
   localparam int WINDOW      = 24;
   localparam int CNT_W       = $clog2(WINDOW + 2);
   localparam int DIVISOR     = WINDOW * (1 << FRAC_W);
   localparam int DIV_HALF    = DIVISOR / 2;
   localparam int DIV_CHUNK_W = 16;
   localparam int QUO_W       = ((SUM_W + DIV_CHUNK_W) / DIV_CHUNK_W) * DIV_CHUNK_W;
   localparam int DIV_CHUNKS  = QUO_W / DIV_CHUNK_W;
   localparam int REM_W       = $clog2(DIVISOR);
   localparam int DIV_V_W     = REM_W + DIV_CHUNK_W;
   localparam int RECIP_SHIFT = DIV_V_W + REM_W;
   localparam int RECIP_W     = DIV_V_W + 2;
   localparam int PROD_W      = DIV_V_W + RECIP_W;
   localparam int STEP_W      = $clog2(DIV_CHUNKS);

   // Reciprocal of the divisor, exact for every partial dividend below DIVISOR << DIV_CHUNK_W
   localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + longint'(DIVISOR) - 1)
                                / longint'(DIVISOR);

   // Command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = SPS_W;
   localparam int ALPHA_RESET = 51;
   localparam int SPS_RESET   = 100;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_SMOOTHING_ALPHA    = 1'b0;
   localparam csr_index_type CSR_SAMPLES_PER_SECOND = 1'b1;

   typedef enum logic [1:0] {
      CMD_SEED,
      CMD_ACCUM,
      CMD_FINAL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic signed [DIFF_W-1:0]  diff;
   } cmd_type;

   typedef struct packed {
      logic [ALPHA_W:0]  alpha;
      logic [SPS_W-1:0]  sps;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_RATE,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_MIX,
      ST_ROUND,
      ST_ACCUM,
      ST_DIV_INIT,
      ST_DIV_MUL,
      ST_DIV_REM,
      ST_EMIT
   } back_state_type;

endpackage

// File: design/srav_req_if.sv
interface srav_req_if;
   import srav_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [ALT_W-1:0]  altitude;

   modport source (output valid, output altitude, input ready);
   modport sink   (input valid, input altitude, output ready);
endinterface

// File: design/srav_rsp_if.sv
interface srav_rsp_if;
   import srav_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  mean_rate;

   modport source (output valid, output mean_rate, input ready);
   modport sink   (input valid, input mean_rate, output ready);
endinterface

// File: design/srav_front.sv
module srav_front (
   input  logic               clock,
   input  logic               reset,
   srav_req_if.sink           req,
   input  logic               queue_full,
   output logic               push_valid,
   output srav_pkg::cmd_type  push_cmd
);
   import srav_pkg::*;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [ALT_W-1:0]  last_ff, last_in;
   logic                     accept;

   // Take a word whenever the queue has room
   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // Classify the sample by its place in the window
   always_comb begin
      count_in      = count_ff;
      last_in       = last_ff;
      push_valid    = 1'b0;
      push_cmd.kind = CMD_ACCUM;
      push_cmd.diff = DIFF_W'(last_ff) - DIFF_W'(req.altitude);
      if (accept) begin
         last_in = req.altitude;
         if (count_ff == '0) begin
            count_in = CNT_W'(1);
         end else if (count_ff == CNT_W'(1)) begin
            count_in = CNT_W'(2);
         end else begin
            push_valid = 1'b1;
            if (count_ff == CNT_W'(2)) begin
               push_cmd.kind = CMD_SEED;
               count_in      = count_ff + CNT_W'(1);
            end else if (count_ff == CNT_W'(WINDOW + 1)) begin
               push_cmd.kind = CMD_FINAL;
               count_in      = '0;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff  <= '0;
      end else begin
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

endmodule

// File: design/srav_queue.sv
module srav_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  srav_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output srav_pkg::cmd_type  head_cmd
);
   import srav_pkg::*;

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue fill count missed a push");

endmodule

// File: design/srav_back.sv
module srav_back (
   input  logic               clock,
   input  logic               reset,
   input  srav_pkg::cfg_type  cfg,
   input  logic               queue_empty,
   input  srav_pkg::cmd_type  head_cmd,
   output logic               pop,
   srav_rsp_if.source         rsp
);
   import srav_pkg::*;

   localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1) << (OUT_W - 1);
   localparam logic [QUO_W-1:0] POS_LIMIT = NEG_LIMIT - QUO_W'(1);

   back_state_type              state_ff, state_in;
   cmd_type                     cmd_ff, cmd_in;
   logic signed [RATE_W-1:0]    rate_ff, rate_in;
   logic signed [NEW_W-1:0]     new_ff, new_in;
   logic signed [OLD_W-1:0]     old_ff, old_in;
   logic signed [MIX_W-1:0]     mix_ff, mix_in;
   logic signed [SMOOTH_W-1:0]  smoothed_ff, smoothed_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [QUO_W-1:0]            quo_ff, quo_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        neg_ff, neg_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]     rsp_data_ff, rsp_data_in;

   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [MUL_P_W-1:0]   mul_p;
   logic [ALPHA_W:0]            keep_w;
   logic signed [SMOOTH_W-1:0]  prev_w;
   logic [MIX_W-1:0]            mix_rnd;
   logic [DIV_V_W-1:0]          div_v;
   logic [DIV_CHUNK_W-1:0]      div_q;
   logic [DIV_V_W-1:0]          div_r;
   logic [SUM_W-1:0]            mag;
   logic signed [OUT_W-1:0]     out_value;
   logic                        out_free;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.mean_rate = rsp_data_ff;
   assign out_free      = !rsp_valid_ff || rsp.ready;

   // Shared multiplier
   assign mul_p = mul_a * mul_b;

   // Weight of the old smoothed value, and seed on the first rate of a window
   assign keep_w = (ALPHA_W + 1)'(ALPHA_ONE) - cfg.alpha;
   assign prev_w = (cmd_ff.kind == CMD_SEED) ? (SMOOTH_W'(rate_ff) <<< FRAC_W) : smoothed_ff;

   // Round half away from zero before the divide by the alpha scale
   assign mix_rnd = mix_ff + MIX_W'(MIX_HALF) - MIX_W'(mix_ff[MIX_W-1]);

   // Bring the next dividend chunk down beside the running remainder
   assign div_v = {rem_ff, quo_ff[QUO_W-1 -: DIV_CHUNK_W]};

   // Take the quotient chunk from the reciprocal product and keep what is left
   assign div_q = prod_ff[RECIP_SHIFT +: DIV_CHUNK_W];
   assign div_r = div_v - DIV_V_W'(div_q) * DIV_V_W'(DIVISOR);

   assign mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // Saturate the quotient to the output range
   always_comb begin
      if (neg_ff) begin
         out_value = (quo_ff > NEG_LIMIT) ? {1'b1, {(OUT_W - 1){1'b0}}}
                                          : -OUT_W'(quo_ff);
      end else begin
         out_value = (quo_ff > POS_LIMIT) ? {1'b0, {(OUT_W - 1){1'b1}}}
                                          : OUT_W'(quo_ff);
      end
   end

   // Sequence one word through the shared multiplier, and the last word of a window on through the divider
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rate_in      = rate_ff;
      new_in       = new_ff;
      old_in       = old_ff;
      mix_in       = mix_ff;
      smoothed_in  = smoothed_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      mul_a        = MUL_A_W'(cmd_ff.diff);
      mul_b        = MUL_B_W'(cfg.sps);
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               cmd_in   = head_cmd;
               state_in = ST_MUL_RATE;
            end
         end
         ST_MUL_RATE: begin
            rate_in  = RATE_W'(mul_p);
            state_in = ST_MUL_NEW;
         end
         ST_MUL_NEW: begin
            mul_a    = MUL_A_W'(rate_ff);
            mul_b    = MUL_B_W'(cfg.alpha);
            new_in   = NEW_W'(mul_p);
            state_in = ST_MUL_OLD;
         end
         ST_MUL_OLD: begin
            mul_a    = prev_w;
            mul_b    = MUL_B_W'(keep_w);
            old_in   = OLD_W'(mul_p);
            state_in = ST_MIX;
         end
         ST_MIX: begin
            mix_in   = (MIX_W'(new_ff) <<< FRAC_W) + MIX_W'(old_ff);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            smoothed_in = mix_rnd[ALPHA_SHIFT +: SMOOTH_W];
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in   = ((cmd_ff.kind == CMD_SEED) ? SUM_W'(0) : sum_ff) + SUM_W'(smoothed_ff);
            state_in = (cmd_ff.kind == CMD_FINAL) ? ST_DIV_INIT : ST_IDLE;
         end
         ST_DIV_INIT: begin
            quo_in   = QUO_W'(mag) + QUO_W'(DIV_HALF);
            neg_in   = sum_ff[SUM_W-1];
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV_MUL;
         end
         ST_DIV_MUL: begin
            prod_in  = PROD_W'(div_v) * PROD_W'(RECIP);
            state_in = ST_DIV_REM;
         end
         ST_DIV_REM: begin
            rem_in   = REM_W'(div_r);
            quo_in   = {quo_ff[QUO_W-DIV_CHUNK_W-1:0], div_q};
            step_in  = step_ff + STEP_W'(1);
            state_in = (step_ff == STEP_W'(DIV_CHUNKS - 1)) ? ST_EMIT : ST_DIV_MUL;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = out_value;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold datapath values
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rate_ff     <= rate_in;
      new_ff      <= new_in;
      old_ff      <= old_in;
      mix_ff      <= mix_in;
      smoothed_ff <= smoothed_in;
      sum_ff      <= sum_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      prod_ff     <= prod_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_final_divides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && cmd_ff.kind == CMD_FINAL) |=> (state_ff == ST_DIV_INIT))
      else $error("last word of a window did not start the divider");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("mean not loaded into output register");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE && !queue_empty))
      else $error("queue popped outside idle or while empty");

endmodule

// File: design/smoothed_rate_averager.sv
// Smoothed rate averager: one signed 24-bit altitude word per sample. Each
// window runs WINDOW+2 samples; the first rate is dropped, the next WINDOW
// rates are scaled by samples_per_second, smoothed with weight smoothing_alpha
// (Q1.8, values above 256 act as 256) and summed, and the last sample of the
// window returns their mean, rounded half away from zero and saturated to 32
// bits. Input words go into a two-entry command queue, so req_if is ready on
// every cycle the queue has room. A word with a rate goes through the back
// end as three passes through its shared 48x17 multiplier, then mix, round
// and accumulate; the last word of a window then runs the mean divider (a
// setup step, then four 16-bit quotient chunks, each a multiply by the
// divisor's reciprocal and a remainder step, then an output load) and then
// waits for the output register to be free. Registers are written through
// csr_* and should only change while the block is idle.
module smoothed_rate_averager (
   input  logic                              clock,
   input  logic                              reset,
   srav_req_if.sink                          req_if,
   srav_rsp_if.source                        rsp_if,
   input  logic                              csr_write_en,
   input  logic [srav_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srav_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import srav_pkg::*;

   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [SPS_W-1:0]    sps_ff, sps_in;
   cfg_type             cfg;
   logic                push_valid;
   cmd_type             push_cmd;
   logic                queue_full;
   logic                queue_empty;
   logic                pop;
   cmd_type             head_cmd;

   // Decode register writes
   always_comb begin
      alpha_in = alpha_ff;
      sps_in   = sps_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SMOOTHING_ALPHA:    alpha_in = csr_wdata[ALPHA_W-1:0];
            CSR_SAMPLES_PER_SECOND: sps_in   = csr_wdata[SPS_W-1:0];
            default: begin
               alpha_in = alpha_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_W'(ALPHA_RESET);
         sps_ff   <= SPS_W'(SPS_RESET);
      end else begin
         alpha_ff <= alpha_in;
         sps_ff   <= sps_in;
      end
   end

   // Clamp the weight to one
   assign cfg.alpha = (alpha_ff > ALPHA_W'(ALPHA_ONE)) ? (ALPHA_W + 1)'(ALPHA_ONE)
                                                      : (ALPHA_W + 1)'(alpha_ff);
   assign cfg.sps   = sps_ff;

   srav_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   srav_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   srav_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp         (rsp_if)
   );

endmodule
